/* design/rdcs_pkg.sv */
`default_nettype none

package rdcs_pkg;

    localparam int MAX_MESSAGE_BYTES = 2048;
    localparam int HEADER_BYTES      = 8;

    localparam int LEN_W   = 12;
    localparam int SEQ_W   = 31;
    localparam int WORD_W  = 32;
    localparam int CFG_W   = 16;
    localparam int TIME_W  = 48;
    localparam int COST_W  = LEN_W + CFG_W;
    localparam int LIMIT_W = 2 * CFG_W;
    localparam int NOWLIM_W = WORD_W + 1;
    localparam int FIT_W   = LEN_W + 1;
    localparam int DROP_W  = 32;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [0:0] CFG_BYTE_TIME_COST = 1'b0;
    localparam logic [0:0] CFG_CHOKE_BACKLOG  = 1'b1;
    localparam logic [CFG_W-1:0] BYTE_TIME_COST_RESET = 16'd400;
    localparam logic [CFG_W-1:0] CHOKE_BACKLOG_RESET  = 16'd200;

    typedef enum logic [1:0] {
        OP_TX         = 2'd0,
        OP_TX_OVF     = 2'd1,
        OP_RX         = 2'd2,
        OP_RX_FOREIGN = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_SENT     = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_FATAL    = 3'd2,
        ST_FOREIGN  = 3'd3,
        ST_STALE    = 3'd4
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] now;
        logic [LEN_W-1:0]  pend_len;
        logic [LEN_W-1:0]  unrel_len;
        logic [SEQ_W-1:0]  rx_seq;
        logic [SEQ_W-1:0]  rx_ack;
        logic              rx_rel_msg;
        logic              rx_rel_ack;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] tx_seq_word;
        logic [WORD_W-1:0] tx_ack_word;
        logic              reliable_included;
        logic [LEN_W-1:0]  reliable_bytes;
        logic              unreliable_included;
        logic [LEN_W-1:0]  packet_bytes;
        logic              pending_taken;
        t_status           status;
        logic [SEQ_W-1:0]  lost_packets;
        logic              can_send;
        logic              can_send_reliable;
        logic [DROP_W-1:0] drop_events;
    } t_result;

endpackage

`default_nettype wire

/* design/reliable_datagram_channel_sequencer.sv */
// An item taken from the front queue passes the back-end registers r1 and r2 and
// is then written into the output queue, whose head drives the output ports. One
// item per cycle while the output queue has room for it and the items in flight.
// Reset (synchronous, active low): queues empty, sequence state and choke clock
// cleared, byte_time_cost to 400 and choke_backlog_bytes to 200.
`default_nettype none

module reliable_datagram_channel_sequencer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_idx,
    input  wire logic [rdcs_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_mode,
    input  wire logic [rdcs_pkg::WORD_W-1:0]   i_now,
    input  wire logic [rdcs_pkg::LEN_W-1:0]    i_pending_length,
    input  wire logic                          i_message_overflow,
    input  wire logic [rdcs_pkg::LEN_W-1:0]    i_unreliable_length,
    input  wire logic [rdcs_pkg::WORD_W-1:0]   i_rx_seq_word,
    input  wire logic [rdcs_pkg::WORD_W-1:0]   i_rx_ack_word,
    input  wire logic                          i_address_match,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [rdcs_pkg::WORD_W-1:0]        o_tx_seq_word,
    output logic [rdcs_pkg::WORD_W-1:0]        o_tx_ack_word,
    output logic                               o_reliable_included,
    output logic [rdcs_pkg::LEN_W-1:0]         o_reliable_bytes,
    output logic                               o_unreliable_included,
    output logic [rdcs_pkg::LEN_W-1:0]         o_packet_bytes,
    output logic                               o_pending_taken,
    output logic [2:0]                         o_status,
    output logic [rdcs_pkg::SEQ_W-1:0]         o_lost_packets,
    output logic                               o_can_send,
    output logic                               o_can_send_reliable,
    output logic [rdcs_pkg::DROP_W-1:0]        o_drop_events
);

    logic [rdcs_pkg::CFG_W-1:0]    r_byte_time_cost;
    logic [rdcs_pkg::CFG_W-1:0]    r_choke_backlog;
    logic                          w_fq_valid;
    rdcs_pkg::t_item               w_fq_item;
    logic                          w_take;
    logic                          w_res_push;
    rdcs_pkg::t_result             w_res;
    rdcs_pkg::t_result             w_head;
    logic [rdcs_pkg::OQ_CNT_W-1:0] w_oq_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_time_cost <= rdcs_pkg::BYTE_TIME_COST_RESET;
            r_choke_backlog  <= rdcs_pkg::CHOKE_BACKLOG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rdcs_pkg::CFG_BYTE_TIME_COST: r_byte_time_cost <= i_cfg_wdata;
                rdcs_pkg::CFG_CHOKE_BACKLOG:  r_choke_backlog  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rdcs_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .o_full              (full),
        .i_mode              (i_mode),
        .i_now               (i_now),
        .i_pending_length    (i_pending_length),
        .i_message_overflow  (i_message_overflow),
        .i_unreliable_length (i_unreliable_length),
        .i_rx_seq_word       (i_rx_seq_word),
        .i_rx_ack_word       (i_rx_ack_word),
        .i_address_match     (i_address_match),
        .o_valid             (w_fq_valid),
        .o_item              (w_fq_item),
        .i_take              (w_take)
    );

    rdcs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_fq_valid),
        .i_item           (w_fq_item),
        .o_take           (w_take),
        .i_byte_time_cost (r_byte_time_cost),
        .i_choke_backlog  (r_choke_backlog),
        .i_oq_count       (w_oq_count),
        .o_push           (w_res_push),
        .o_res            (w_res)
    );

    rdcs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_head),
        .o_count (w_oq_count)
    );

    assign o_tx_seq_word         = w_head.tx_seq_word;
    assign o_tx_ack_word         = w_head.tx_ack_word;
    assign o_reliable_included   = w_head.reliable_included;
    assign o_reliable_bytes      = w_head.reliable_bytes;
    assign o_unreliable_included = w_head.unreliable_included;
    assign o_packet_bytes        = w_head.packet_bytes;
    assign o_pending_taken       = w_head.pending_taken;
    assign o_status              = w_head.status;
    assign o_lost_packets        = w_head.lost_packets;
    assign o_can_send            = w_head.can_send;
    assign o_can_send_reliable   = w_head.can_send_reliable;
    assign o_drop_events         = w_head.drop_events;

endmodule

`default_nettype wire

/* design/rdcs_front.sv */
`default_nettype none

module rdcs_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic                          i_mode,
    input  wire logic [rdcs_pkg::WORD_W-1:0]   i_now,
    input  wire logic [rdcs_pkg::LEN_W-1:0]    i_pending_length,
    input  wire logic                          i_message_overflow,
    input  wire logic [rdcs_pkg::LEN_W-1:0]    i_unreliable_length,
    input  wire logic [rdcs_pkg::WORD_W-1:0]   i_rx_seq_word,
    input  wire logic [rdcs_pkg::WORD_W-1:0]   i_rx_ack_word,
    input  wire logic                          i_address_match,
    output logic                               o_valid,
    output rdcs_pkg::t_item                    o_item,
    input  wire logic                          i_take
);

    rdcs_pkg::t_item               r_q [rdcs_pkg::FQ_DEPTH];
    logic [rdcs_pkg::FQ_PTR_W-1:0] r_wr_ptr;
    logic [rdcs_pkg::FQ_PTR_W-1:0] r_rd_ptr;
    logic [rdcs_pkg::FQ_CNT_W-1:0] r_cnt;
    rdcs_pkg::t_item               w_cls;
    logic                          w_wr;
    logic                          w_rd;

    always_comb begin
        w_cls = '0;
        if (!i_mode) begin
            w_cls.op = i_message_overflow ? rdcs_pkg::OP_TX_OVF : rdcs_pkg::OP_TX;
        end else begin
            w_cls.op = i_address_match ? rdcs_pkg::OP_RX : rdcs_pkg::OP_RX_FOREIGN;
        end
        w_cls.now = i_now;
        if (i_pending_length > rdcs_pkg::LEN_W'(rdcs_pkg::MAX_MESSAGE_BYTES)) begin
            w_cls.pend_len = rdcs_pkg::LEN_W'(rdcs_pkg::MAX_MESSAGE_BYTES);
        end else begin
            w_cls.pend_len = i_pending_length;
        end
        w_cls.unrel_len  = i_unreliable_length;
        w_cls.rx_seq     = i_rx_seq_word[rdcs_pkg::SEQ_W-1:0];
        w_cls.rx_ack     = i_rx_ack_word[rdcs_pkg::SEQ_W-1:0];
        w_cls.rx_rel_msg = i_rx_seq_word[rdcs_pkg::WORD_W-1];
        w_cls.rx_rel_ack = i_rx_ack_word[rdcs_pkg::WORD_W-1];
    end

    assign o_full  = (r_cnt == rdcs_pkg::FQ_CNT_W'(rdcs_pkg::FQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/rdcs_back.sv */
`default_nettype none

module rdcs_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire rdcs_pkg::t_item               i_item,
    output logic                               o_take,
    input  wire logic [rdcs_pkg::CFG_W-1:0]    i_byte_time_cost,
    input  wire logic [rdcs_pkg::CFG_W-1:0]    i_choke_backlog,
    input  wire logic [rdcs_pkg::OQ_CNT_W-1:0] i_oq_count,
    output logic                               o_push,
    output rdcs_pkg::t_result                  o_res
);

    localparam int CRED_W = rdcs_pkg::OQ_CNT_W + 1;

    logic [rdcs_pkg::SEQ_W-1:0]  r_out_seq,          n_out_seq;
    logic [rdcs_pkg::SEQ_W-1:0]  r_in_seq,           n_in_seq;
    logic [rdcs_pkg::SEQ_W-1:0]  r_in_acked,         n_in_acked;
    logic                        r_in_rel_acked,     n_in_rel_acked;
    logic                        r_out_rel_bit,      n_out_rel_bit;
    logic                        r_in_rel_bit,       n_in_rel_bit;
    logic [rdcs_pkg::SEQ_W-1:0]  r_last_rel_seq,     n_last_rel_seq;
    logic [rdcs_pkg::LEN_W-1:0]  r_rel_len,          n_rel_len;
    logic [rdcs_pkg::DROP_W-1:0] r_drop,             n_drop;
    logic [rdcs_pkg::TIME_W-1:0] r_clear,            n_clear;
    logic [rdcs_pkg::LIMIT_W-1:0] r_limit;

    rdcs_pkg::t_result           s1_res;
    logic                        s1_upd;
    logic [rdcs_pkg::LEN_W-1:0]  s1_pkt;
    logic                        w_send_rel;
    logic                        w_take_pend;
    logic [rdcs_pkg::FIT_W-1:0]  w_fit_sum;
    logic [rdcs_pkg::SEQ_W-1:0]  w_lost;

    logic                        r1_v;
    rdcs_pkg::t_result           r1_res;
    logic                        r1_upd;
    logic [rdcs_pkg::LEN_W-1:0]  r1_pkt;
    logic [rdcs_pkg::WORD_W-1:0] r1_now;

    logic                          r2_v;
    rdcs_pkg::t_result             r2_res;
    logic                          r2_upd;
    logic [rdcs_pkg::COST_W-1:0]   r2_cost;
    logic [rdcs_pkg::WORD_W-1:0]   r2_now;
    logic [rdcs_pkg::NOWLIM_W-1:0] r2_nowlim;

    logic [rdcs_pkg::TIME_W-1:0] w_base;
    logic [rdcs_pkg::TIME_W:0]   w_sum;
    logic [rdcs_pkg::TIME_W-1:0] w_sat;
    logic                        w_cs;

    assign o_take = i_valid && ((CRED_W'(i_oq_count) + CRED_W'(r1_v) + CRED_W'(r2_v))
                                < CRED_W'(rdcs_pkg::OQ_DEPTH));

    always_comb begin
        n_out_seq      = r_out_seq;
        n_in_seq       = r_in_seq;
        n_in_acked     = r_in_acked;
        n_in_rel_acked = r_in_rel_acked;
        n_out_rel_bit  = r_out_rel_bit;
        n_in_rel_bit   = r_in_rel_bit;
        n_last_rel_seq = r_last_rel_seq;
        n_rel_len      = r_rel_len;
        n_drop         = r_drop;
        s1_res         = '0;
        s1_upd         = 1'b0;
        s1_pkt         = '0;
        w_send_rel     = 1'b0;
        w_take_pend    = 1'b0;
        w_fit_sum      = '0;
        w_lost         = '0;
        if (o_take) begin
            case (i_item.op)
                rdcs_pkg::OP_TX: begin
                    w_send_rel  = (r_in_acked > r_last_rel_seq)
                                  && (r_in_rel_acked != r_out_rel_bit);
                    w_take_pend = (r_rel_len == '0) && (i_item.pend_len != '0);
                    if (w_take_pend) begin
                        n_rel_len     = i_item.pend_len;
                        n_out_rel_bit = ~r_out_rel_bit;
                        w_send_rel    = 1'b1;
                    end
                    s1_res.pending_taken = w_take_pend;
                    s1_res.tx_seq_word   = {w_send_rel, r_out_seq};
                    s1_res.tx_ack_word   = {r_in_rel_bit, r_in_seq};
                    n_out_seq            = r_out_seq + 1'b1;
                    s1_pkt               = rdcs_pkg::LEN_W'(rdcs_pkg::HEADER_BYTES);
                    if (w_send_rel) begin
                        s1_pkt                   = s1_pkt + n_rel_len;
                        n_last_rel_seq           = n_out_seq;
                        s1_res.reliable_included = 1'b1;
                    end
                    w_fit_sum = rdcs_pkg::FIT_W'(s1_pkt) + rdcs_pkg::FIT_W'(i_item.unrel_len);
                    if (w_fit_sum <= rdcs_pkg::FIT_W'(rdcs_pkg::MAX_MESSAGE_BYTES
                                                      + rdcs_pkg::HEADER_BYTES)) begin
                        s1_pkt                     = w_fit_sum[rdcs_pkg::LEN_W-1:0];
                        s1_res.unreliable_included = 1'b1;
                    end
                    s1_res.packet_bytes = s1_pkt;
                    s1_res.status       = rdcs_pkg::ST_SENT;
                    s1_upd              = 1'b1;
                end
                rdcs_pkg::OP_TX_OVF: begin
                    s1_res.status = rdcs_pkg::ST_FATAL;
                end
                rdcs_pkg::OP_RX: begin
                    if (i_item.rx_seq <= r_in_seq) begin
                        s1_res.status = rdcs_pkg::ST_STALE;
                    end else begin
                        w_lost = i_item.rx_seq - r_in_seq - 1'b1;
                        if (w_lost != '0) begin
                            n_drop = r_drop + 1'b1;
                        end
                        if (i_item.rx_rel_ack == r_out_rel_bit) begin
                            n_rel_len = '0;
                        end
                        n_in_seq       = i_item.rx_seq;
                        n_in_acked     = i_item.rx_ack;
                        n_in_rel_acked = i_item.rx_rel_ack;
                        if (i_item.rx_rel_msg) begin
                            n_in_rel_bit = ~r_in_rel_bit;
                        end
                        s1_res.lost_packets = w_lost;
                        s1_res.status       = rdcs_pkg::ST_ACCEPTED;
                    end
                end
                rdcs_pkg::OP_RX_FOREIGN: begin
                    s1_res.status = rdcs_pkg::ST_FOREIGN;
                end
                default: begin
                    s1_res.status = rdcs_pkg::ST_FOREIGN;
                end
            endcase
        end
        s1_res.reliable_bytes = n_rel_len;
        s1_res.drop_events    = n_drop;
    end

    always_comb begin
        if (r_clear < rdcs_pkg::TIME_W'(r2_now)) begin
            w_base = rdcs_pkg::TIME_W'(r2_now);
        end else begin
            w_base = r_clear;
        end
        w_sum = (rdcs_pkg::TIME_W + 1)'(w_base) + (rdcs_pkg::TIME_W + 1)'(r2_cost);
        w_sat = w_sum[rdcs_pkg::TIME_W] ? '1 : w_sum[rdcs_pkg::TIME_W-1:0];
        n_clear = (r2_v && r2_upd) ? w_sat : r_clear;
        w_cs = n_clear < rdcs_pkg::TIME_W'(r2_nowlim);
        o_res = r2_res;
        o_res.can_send          = w_cs;
        o_res.can_send_reliable = w_cs && (r2_res.reliable_bytes == '0);
    end

    assign o_push = r2_v;

    always_ff @(posedge i_clk) begin
        r_limit   <= rdcs_pkg::LIMIT_W'(i_choke_backlog)
                     * rdcs_pkg::LIMIT_W'(i_byte_time_cost);
        r1_res    <= s1_res;
        r1_upd    <= s1_upd;
        r1_pkt    <= s1_pkt;
        r1_now    <= i_item.now;
        r2_res    <= r1_res;
        r2_upd    <= r1_upd;
        r2_cost   <= rdcs_pkg::COST_W'(r1_pkt) * rdcs_pkg::COST_W'(i_byte_time_cost);
        r2_now    <= r1_now;
        r2_nowlim <= rdcs_pkg::NOWLIM_W'(r1_now) + rdcs_pkg::NOWLIM_W'(r_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_seq      <= '0;
            r_in_seq       <= '0;
            r_in_acked     <= '0;
            r_in_rel_acked <= 1'b0;
            r_out_rel_bit  <= 1'b0;
            r_in_rel_bit   <= 1'b0;
            r_last_rel_seq <= '0;
            r_rel_len      <= '0;
            r_drop         <= '0;
            r_clear        <= '0;
            r1_v           <= 1'b0;
            r2_v           <= 1'b0;
        end else begin
            r_out_seq      <= n_out_seq;
            r_in_seq       <= n_in_seq;
            r_in_acked     <= n_in_acked;
            r_in_rel_acked <= n_in_rel_acked;
            r_out_rel_bit  <= n_out_rel_bit;
            r_in_rel_bit   <= n_in_rel_bit;
            r_last_rel_seq <= n_last_rel_seq;
            r_rel_len      <= n_rel_len;
            r_drop         <= n_drop;
            r_clear        <= n_clear;
            r1_v           <= o_take;
            r2_v           <= r1_v;
        end
    end

endmodule

`default_nettype wire

/* design/rdcs_outq.sv */
`default_nettype none

module rdcs_outq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire rdcs_pkg::t_result             i_data,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output rdcs_pkg::t_result                  o_data,
    output logic [rdcs_pkg::OQ_CNT_W-1:0]      o_count
);

    rdcs_pkg::t_result             r_q [rdcs_pkg::OQ_DEPTH];
    logic [rdcs_pkg::OQ_PTR_W-1:0] r_wr_ptr;
    logic [rdcs_pkg::OQ_PTR_W-1:0] r_rd_ptr;
    logic [rdcs_pkg::OQ_CNT_W-1:0] r_cnt;
    logic                          w_rd;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_count = r_cnt;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* verif/reliable_datagram_channel_sequencer_test.sv */
`timescale 1ns / 100ps

module reliable_datagram_channel_sequencer_test;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic MODE_TX = 1'b0;
    localparam logic MODE_RX = 1'b1;

    localparam logic [rdcs_pkg::SEQ_W-1:0]  SEQ_MAX        = '1;
    localparam logic [rdcs_pkg::TIME_W-1:0] CHOKE_MAX      = '1;
    localparam logic [rdcs_pkg::TIME_W-1:0] RESYNC_CEILING = 48'h0000_C000_0000;

    typedef struct {
        logic                        mode;
        logic [rdcs_pkg::WORD_W-1:0] now_us;
        logic [rdcs_pkg::LEN_W-1:0]  pend;
        logic                        ovf;
        logic [rdcs_pkg::LEN_W-1:0]  unrel;
        logic [rdcs_pkg::WORD_W-1:0] rseq;
        logic [rdcs_pkg::WORD_W-1:0] rack;
        logic                        addr;
    } t_chan_item;

    logic                        i_clk               = 1'b0;
    logic                        i_rst_n             = 1'b0;
    logic                        i_cfg_we            = 1'b0;
    logic [0:0]                  i_cfg_idx           = '0;
    logic [rdcs_pkg::CFG_W-1:0]  i_cfg_wdata         = '0;
    logic                        push                = 1'b0;
    logic                        full;
    logic                        i_mode              = 1'b0;
    logic [rdcs_pkg::WORD_W-1:0] i_now               = '0;
    logic [rdcs_pkg::LEN_W-1:0]  i_pending_length    = '0;
    logic                        i_message_overflow  = 1'b0;
    logic [rdcs_pkg::LEN_W-1:0]  i_unreliable_length = '0;
    logic [rdcs_pkg::WORD_W-1:0] i_rx_seq_word       = '0;
    logic [rdcs_pkg::WORD_W-1:0] i_rx_ack_word       = '0;
    logic                        i_address_match     = 1'b0;
    logic                        empty;
    logic                        pop                 = 1'b0;
    logic [rdcs_pkg::WORD_W-1:0] o_tx_seq_word;
    logic [rdcs_pkg::WORD_W-1:0] o_tx_ack_word;
    logic                        o_reliable_included;
    logic [rdcs_pkg::LEN_W-1:0]  o_reliable_bytes;
    logic                        o_unreliable_included;
    logic [rdcs_pkg::LEN_W-1:0]  o_packet_bytes;
    logic                        o_pending_taken;
    logic [2:0]                  o_status;
    logic [rdcs_pkg::SEQ_W-1:0]  o_lost_packets;
    logic                        o_can_send;
    logic                        o_can_send_reliable;
    logic [rdcs_pkg::DROP_W-1:0] o_drop_events;

    reliable_datagram_channel_sequencer dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_wdata           (i_cfg_wdata),
        .push                  (push),
        .full                  (full),
        .i_mode                (i_mode),
        .i_now                 (i_now),
        .i_pending_length      (i_pending_length),
        .i_message_overflow    (i_message_overflow),
        .i_unreliable_length   (i_unreliable_length),
        .i_rx_seq_word         (i_rx_seq_word),
        .i_rx_ack_word         (i_rx_ack_word),
        .i_address_match       (i_address_match),
        .empty                 (empty),
        .pop                   (pop),
        .o_tx_seq_word         (o_tx_seq_word),
        .o_tx_ack_word         (o_tx_ack_word),
        .o_reliable_included   (o_reliable_included),
        .o_reliable_bytes      (o_reliable_bytes),
        .o_unreliable_included (o_unreliable_included),
        .o_packet_bytes        (o_packet_bytes),
        .o_pending_taken       (o_pending_taken),
        .o_status              (o_status),
        .o_lost_packets        (o_lost_packets),
        .o_can_send            (o_can_send),
        .o_can_send_reliable   (o_can_send_reliable),
        .o_drop_events         (o_drop_events)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // channel state mirror
    logic [rdcs_pkg::SEQ_W-1:0]  tx_seq_ctr     = '0;
    logic [rdcs_pkg::SEQ_W-1:0]  rx_seq_seen    = '0;
    logic [rdcs_pkg::SEQ_W-1:0]  rx_acked       = '0;
    logic                        rx_rel_acked   = 1'b0;
    logic                        tx_rel_bit     = 1'b0;
    logic                        rx_rel_bit     = 1'b0;
    logic [rdcs_pkg::SEQ_W-1:0]  rel_seq_mark   = '0;
    logic [rdcs_pkg::LEN_W-1:0]  slot_len       = '0;
    logic [rdcs_pkg::TIME_W-1:0] choke_time     = '0;
    logic [rdcs_pkg::DROP_W-1:0] gap_count      = '0;
    logic                        overflow_seen  = 1'b0;
    logic [rdcs_pkg::CFG_W-1:0]  cost_per_byte  = rdcs_pkg::BYTE_TIME_COST_RESET;
    logic [rdcs_pkg::CFG_W-1:0]  backlog_bytes  = rdcs_pkg::CHOKE_BACKLOG_RESET;

    logic [rdcs_pkg::WORD_W-1:0] clock_now      = '0;
    bit                          idle_on        = 1'b1;
    int                          pop_hold       = 0;
    int                          error_count    = 0;
    int unsigned                 cycle_count    = 0;
    rdcs_pkg::t_result           expected_q[$];

    function automatic rdcs_pkg::t_result predict_packet(input t_chan_item it);
        rdcs_pkg::t_result          r;
        logic                       resend;
        logic [63:0]                pkt;
        logic [63:0]                cost;
        logic [63:0]                choke_next;
        logic [63:0]                limit;
        logic [rdcs_pkg::SEQ_W-1:0] seq;
        logic [rdcs_pkg::SEQ_W-1:0] lost;
        r = '0;
        lost = '0;
        if (it.mode == MODE_TX) begin
            if (it.ovf) begin
                overflow_seen = 1'b1;
                r.status = rdcs_pkg::ST_FATAL;
            end else begin
                resend = (rx_acked > rel_seq_mark) && (rx_rel_acked != tx_rel_bit);
                if (slot_len == '0 && it.pend != '0) begin
                    slot_len = (it.pend > rdcs_pkg::MAX_MESSAGE_BYTES)
                               ? rdcs_pkg::LEN_W'(rdcs_pkg::MAX_MESSAGE_BYTES) : it.pend;
                    tx_rel_bit = ~tx_rel_bit;
                    resend = 1'b1;
                    r.pending_taken = 1'b1;
                end
                r.tx_seq_word = {resend, tx_seq_ctr};
                r.tx_ack_word = {rx_rel_bit, rx_seq_seen};
                tx_seq_ctr = tx_seq_ctr + 1'b1;
                pkt = 64'(rdcs_pkg::HEADER_BYTES);
                if (resend) begin
                    pkt = pkt + slot_len;
                    rel_seq_mark = tx_seq_ctr;
                    r.reliable_included = 1'b1;
                end
                if (64'(rdcs_pkg::MAX_MESSAGE_BYTES + rdcs_pkg::HEADER_BYTES)
                    >= pkt + it.unrel) begin
                    pkt = pkt + it.unrel;
                    r.unreliable_included = 1'b1;
                end
                cost = pkt * cost_per_byte;
                choke_next = (choke_time < it.now_us) ? it.now_us + cost : choke_time + cost;
                choke_time = (choke_next > CHOKE_MAX) ? CHOKE_MAX
                                                      : choke_next[rdcs_pkg::TIME_W-1:0];
                r.packet_bytes = pkt[rdcs_pkg::LEN_W-1:0];
                r.status = rdcs_pkg::ST_SENT;
            end
        end else if (!it.addr) begin
            r.status = rdcs_pkg::ST_FOREIGN;
        end else begin
            seq = it.rseq[rdcs_pkg::SEQ_W-1:0];
            if (seq <= rx_seq_seen) begin
                r.status = rdcs_pkg::ST_STALE;
            end else begin
                lost = seq - rx_seq_seen - 1'b1;
                if (lost != '0)
                    gap_count = gap_count + 1'b1;
                if (it.rack[rdcs_pkg::WORD_W-1] == tx_rel_bit)
                    slot_len = '0;
                rx_seq_seen = seq;
                rx_acked = it.rack[rdcs_pkg::SEQ_W-1:0];
                rx_rel_acked = it.rack[rdcs_pkg::WORD_W-1];
                if (it.rseq[rdcs_pkg::WORD_W-1])
                    rx_rel_bit = ~rx_rel_bit;
                r.status = rdcs_pkg::ST_ACCEPTED;
            end
        end
        limit = 64'(it.now_us) + 64'(backlog_bytes) * 64'(cost_per_byte);
        r.can_send = 64'(choke_time) < limit;
        r.can_send_reliable = r.can_send && (slot_len == '0);
        r.reliable_bytes = slot_len;
        r.lost_packets = lost;
        r.drop_events = gap_count;
        return r;
    endfunction

    function automatic t_chan_item blank_packet(input logic mode,
                                                input logic [rdcs_pkg::WORD_W-1:0] now_us);
        t_chan_item it;
        it.mode = mode;
        it.now_us = now_us;
        it.pend = '0;
        it.ovf = 1'b0;
        it.unrel = '0;
        it.rseq = '0;
        it.rack = '0;
        it.addr = 1'b1;
        return it;
    endfunction

    function automatic logic [rdcs_pkg::LEN_W-1:0] random_length();
        logic [rdcs_pkg::LEN_W-1:0] len;
        case ($urandom_range(0, 3))
            0: len = '0;
            1: len = rdcs_pkg::LEN_W'($urandom_range(1, 64));
            2: len = rdcs_pkg::LEN_W'($urandom_range(1, rdcs_pkg::MAX_MESSAGE_BYTES));
            default: len = rdcs_pkg::LEN_W'($urandom);
        endcase
        return len;
    endfunction

    function automatic t_chan_item random_packet();
        t_chan_item                 it;
        int                         pick;
        logic [rdcs_pkg::SEQ_W-1:0] seq;
        logic [rdcs_pkg::SEQ_W-1:0] ack;
        logic                       ack_bit;
        clock_now = clock_now + rdcs_pkg::WORD_W'($urandom_range(0, 250000));
        it.mode = MODE_TX;
        it.now_us = clock_now;
        it.pend = rdcs_pkg::LEN_W'($urandom);
        it.ovf = 1'($urandom);
        it.unrel = rdcs_pkg::LEN_W'($urandom);
        it.rseq = $urandom;
        it.rack = $urandom;
        it.addr = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            it.pend = random_length();
            it.unrel = random_length();
            it.ovf = ($urandom_range(0, 19) == 0);
            if (it.ovf)
                it.now_us = $urandom;
        end else if (pick < 90) begin
            it.mode = MODE_RX;
            it.addr = 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                    seq = rx_seq_seen + 1'b1 + rdcs_pkg::SEQ_W'($urandom_range(1, 8));
                4: seq = rx_seq_seen + 1'b1 + rdcs_pkg::SEQ_W'($urandom_range(9, 65535));
                5: seq = rdcs_pkg::SEQ_W'($urandom_range(0, rx_seq_seen));
                default: seq = rx_seq_seen + 1'b1;
            endcase
            if (rx_seq_seen > SEQ_MAX - 31'd70000)
                seq = rx_seq_seen;
            case ($urandom_range(0, 5))
                0, 1, 2: ack = tx_seq_ctr;
                3: ack = tx_seq_ctr - rdcs_pkg::SEQ_W'($urandom_range(0, 3));
                4: ack = rel_seq_mark;
                default: ack = rdcs_pkg::SEQ_W'($urandom);
            endcase
            ack_bit = ($urandom_range(0, 4) < 3) ? tx_rel_bit : ~tx_rel_bit;
            it.rseq = {1'($urandom), seq};
            it.rack = {ack_bit, ack};
            if ($urandom_range(0, 3) == 0)
                it.now_us = $urandom;
        end else begin
            it.mode = MODE_RX;
            it.addr = 1'b0;
            it.now_us = $urandom;
        end
        return it;
    endfunction

    task automatic send_packet(input t_chan_item it);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_mode <= it.mode;
        i_now <= it.now_us;
        i_pending_length <= it.pend;
        i_message_overflow <= it.ovf;
        i_unreliable_length <= it.unrel;
        i_rx_seq_word <= it.rseq;
        i_rx_ack_word <= it.rack;
        i_address_match <= it.addr;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        expected_q.push_back(predict_packet(it));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [0:0] idx,
                                  input logic [rdcs_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rdcs_pkg::CFG_BYTE_TIME_COST)
            cost_per_byte = value;
        else
            backlog_bytes = value;
    endtask

    task automatic apply_settings(input logic [rdcs_pkg::CFG_W-1:0] cost,
                                  input logic [rdcs_pkg::CFG_W-1:0] backlog);
        wait_results_drained();
        write_register(rdcs_pkg::CFG_BYTE_TIME_COST, cost);
        write_register(rdcs_pkg::CFG_CHOKE_BACKLOG, backlog);
        // pull the time base up to the choke clock so both choke outcomes stay reachable
        if (choke_time > clock_now && choke_time < RESYNC_CEILING)
            clock_now = choke_time[rdcs_pkg::WORD_W-1:0]
                        - rdcs_pkg::WORD_W'($urandom_range(0, 100000));
    endtask

    task automatic test_directed_cases();
        t_chan_item it;
        it = blank_packet(MODE_TX, '0);
        send_packet(it);
        it = blank_packet(MODE_TX, 32'd100);
        it.pend = 12'd100;
        it.unrel = 12'd2048;
        send_packet(it);
        it = blank_packet(MODE_TX, 32'd200);
        it.pend = 12'hFFF;
        send_packet(it);
        it = blank_packet(MODE_RX, 32'd300);
        it.addr = 1'b0;
        it.rseq = 32'd5;
        send_packet(it);
        it = blank_packet(MODE_RX, 32'd300);
        it.rseq = {1'b0, rx_seq_seen};
        send_packet(it);
        // peer acks with the old bit: hold the slot and arm a resend
        it = blank_packet(MODE_RX, 32'd400);
        it.rseq = {1'b0, rx_seq_seen + 1'b1};
        it.rack = {~tx_rel_bit, tx_seq_ctr};
        send_packet(it);
        it = blank_packet(MODE_TX, 32'd500);
        send_packet(it);
        it = blank_packet(MODE_RX, 32'd600);
        it.rseq = {1'b1, rx_seq_seen + 31'd5};
        it.rack = {tx_rel_bit, tx_seq_ctr};
        send_packet(it);
        it = blank_packet(MODE_TX, 32'd700);
        it.pend = 12'hFFF;
        it.unrel = 12'hFFF;
        send_packet(it);
        it = blank_packet(MODE_TX, 32'hFFFF_0000);
        it.ovf = 1'b1;
        it.pend = 12'h800;
        it.unrel = 12'h7FF;
        send_packet(it);
        it = blank_packet(MODE_RX, 32'd800);
        it.rseq = {1'b0, rx_seq_seen + 1'b1};
        it.rack = {tx_rel_bit, tx_seq_ctr};
        send_packet(it);
        it = blank_packet(MODE_TX, 32'd900);
        it.unrel = 12'd2048;
        send_packet(it);
        it = blank_packet(MODE_TX, 32'd1000);
        it.unrel = 12'd2049;
        send_packet(it);
        it = blank_packet(MODE_TX, 32'd1100);
        it.pend = 12'd1;
        it.unrel = 12'd2047;
        send_packet(it);
    endtask

    task automatic test_config_sweep();
        logic [rdcs_pkg::CFG_W-1:0] cost;
        logic [rdcs_pkg::CFG_W-1:0] backlog;
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: begin cost = 16'd1;    backlog = 16'd0;    end
                1: begin cost = 16'd1;    backlog = 16'hFFFF; end
                2: begin cost = 16'hFFFF; backlog = 16'd0;    end
                3: begin cost = 16'hFFFF; backlog = 16'hFFFF; end
                default: begin
                    cost    = rdcs_pkg::BYTE_TIME_COST_RESET;
                    backlog = rdcs_pkg::CHOKE_BACKLOG_RESET;
                end
            endcase
            apply_settings(cost, backlog);
            repeat (20) send_packet(random_packet());
        end
    endtask

    task automatic test_random_traffic();
        logic [rdcs_pkg::CFG_W-1:0] cost;
        for (int chunk = 0; chunk < 8; chunk++) begin
            if ($urandom_range(0, 3) == 0) begin
                apply_settings(rdcs_pkg::BYTE_TIME_COST_RESET, rdcs_pkg::CHOKE_BACKLOG_RESET);
            end else begin
                cost = ($urandom_range(0, 3) == 0)
                       ? rdcs_pkg::CFG_W'($urandom_range(1, 65535))
                       : rdcs_pkg::CFG_W'($urandom_range(1, 800));
                apply_settings(cost, rdcs_pkg::CFG_W'($urandom_range(0, 65535)));
            end
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (100) send_packet(random_packet());
        end
        idle_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (100) send_packet(random_packet());
    endtask

    task automatic test_counter_extremes();
        t_chan_item it;
        it = blank_packet(MODE_RX, 32'hFFFF_FFFF);
        it.rseq = 32'hFFFF_FFFF;
        it.rack = 32'hFFFF_FFFF;
        send_packet(it);
        send_packet(it);
        it = blank_packet(MODE_TX, 32'hFFFF_FFFF);
        it.pend = 12'hFFF;
        it.unrel = 12'hFFF;
        send_packet(it);
        it = blank_packet(MODE_TX, '0);
        it.unrel = 12'd16;
        send_packet(it);
        it = blank_packet(MODE_RX, '0);
        send_packet(it);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            pop_hold <= $urandom_range(0, 3);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        rdcs_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (expected_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transfer, expected none, actual status %0h",
                         $time, o_status);
            end else begin
                want = expected_q.pop_front();
                check_field("tx_seq_word", want.tx_seq_word, o_tx_seq_word);
                check_field("tx_ack_word", want.tx_ack_word, o_tx_ack_word);
                check_field("reliable_included", want.reliable_included, o_reliable_included);
                check_field("reliable_bytes", want.reliable_bytes, o_reliable_bytes);
                check_field("unreliable_included", want.unreliable_included,
                            o_unreliable_included);
                check_field("packet_bytes", want.packet_bytes, o_packet_bytes);
                check_field("pending_taken", want.pending_taken, o_pending_taken);
                check_field("status", want.status, o_status);
                check_field("lost_packets", want.lost_packets, o_lost_packets);
                check_field("can_send", want.can_send, o_can_send);
                check_field("can_send_reliable", want.can_send_reliable, o_can_send_reliable);
                check_field("drop_events", want.drop_events, o_drop_events);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("reliable_datagram_channel_sequencer_test: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_config_sweep();
        test_random_traffic();
        test_back_to_back();
        test_counter_extremes();
        wait_results_drained();
        if (error_count == 0)
            $display("reliable_datagram_channel_sequencer_test: done, clean");
        else
            $display("reliable_datagram_channel_sequencer_test: done, errors");
        $finish;
    end

endmodule

/* sim.f */
design/rdcs_pkg.sv
design/rdcs_front.sv
design/rdcs_back.sv
design/rdcs_outq.sv
design/reliable_datagram_channel_sequencer.sv
verif/reliable_datagram_channel_sequencer_test.sv
